// File: rtl/core/tkpil_pkg.sv
// Shared types and constants of the top-K pair insertion list.
package tkpil_pkg;

    localparam int KEY_W = 32;
    localparam int ID_W  = 31;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [ID_W-1:0]  id_t;
    typedef logic [0:0]       reg_idx_t;

    localparam reg_idx_t REG_ORDER_MODE      = 1'b0;
    localparam reg_idx_t REG_EQUAL_TOLERANCE = 1'b1;

    localparam logic ORDER_CLOSEST  = 1'b0;
    localparam logic ORDER_FURTHEST = 1'b1;

    localparam key_t TOLERANCE_RESET = 32'd1;
    localparam key_t WORST_CLOSEST   = 32'hFFFF_FFFF;
    localparam key_t WORST_FURTHEST  = 32'h0000_0000;

    typedef struct packed {
        key_t key;
        id_t  first_id;
        id_t  second_id;
    } entry_t;

    typedef struct packed {
        logic duplicate;
        logic beaten;
    } cmp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_WRITE,
        ST_RESULT
    } state_t;

endpackage

// File: rtl/core/tkpil_if.sv
// Request channels of the top-K pair insertion list.
interface tkpil_in_if;
    logic                valid;
    logic                ready;
    tkpil_pkg::key_t     pair_key;
    tkpil_pkg::id_t      first_id;
    tkpil_pkg::id_t      second_id;

    modport source (output valid, pair_key, first_id, second_id, input ready);
    modport sink   (input valid, pair_key, first_id, second_id, output ready);
endinterface

interface tkpil_out_if;
    logic                valid;
    logic                ready;
    tkpil_pkg::key_t     kth_key;
    logic                kth_valid;
    logic                was_inserted;

    modport source (output valid, kth_key, kth_valid, was_inserted, input ready);
    modport sink   (input valid, kth_key, kth_valid, was_inserted, output ready);
endinterface

// File: rtl/core/tkpil_slot_cmp.sv
// Compares a candidate pair against one stored list entry.
module tkpil_slot_cmp (
    input  tkpil_pkg::entry_t cand,
    input  tkpil_pkg::entry_t held,
    input  logic              order_mode,
    input  tkpil_pkg::key_t   tolerance,
    output tkpil_pkg::cmp_t   result
);
    import tkpil_pkg::*;

    key_t diff;
    logic near_key;
    logic same_pair;
    logic better;

    always_comb
    begin
        diff = (cand.key > held.key) ? (cand.key - held.key) : (held.key - cand.key);
        near_key = (diff < tolerance);
        // The pair is unordered, so both id assignments match.
        same_pair = ((cand.first_id == held.first_id) && (cand.second_id == held.second_id))
                 || ((cand.first_id == held.second_id) && (cand.second_id == held.first_id));
        better = (order_mode == ORDER_FURTHEST) ? (cand.key > held.key)
                                                : (cand.key < held.key);
        result.duplicate = near_key && same_pair;
        result.beaten    = !near_key && better;
    end

endmodule

// File: rtl/core/top_k_pair_insertion_list.sv
// Top level of the top-K pair insertion list: control, list memory and register port.
//
// The list of the best LIST_DEPTH pairs lives in one synchronous memory with a registered
// read port; a fill count stands in for per-entry valid bits, since valid entries always
// form a prefix. A request is handled one at a time: it is accepted, the entries are
// scanned from the front up to the insertion point P, the entries behind P are moved
// down one place, the new pair is written to P and the result is presented. A repeat,
// or a full list that the pair does not beat, skips the moving and the writing. The
// result step waits while the previous result is still held. The result register frees
// the input side: the next request is taken while a result still waits. No clearing
// pass is needed after reset.
module top_k_pair_insertion_list #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tkpil_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tkpil_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tkpil_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    tkpil_in_if.sink                         pair_in,
    tkpil_out_if.source                      res_out
);
    import tkpil_pkg::*;

    localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(LIST_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LIST_DEPTH);

    // Configuration registers.
    logic     order_mode_reg;
    key_t     tolerance_reg;
    reg_idx_t cfg_idx;
    logic     cfg_write;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (cfg_idx == REG_EQUAL_TOLERANCE) ? tolerance_reg
                                                        : {31'd0, order_mode_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_mode_reg <= ORDER_CLOSEST;
            tolerance_reg  <= TOLERANCE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_ORDER_MODE:      order_mode_reg <= pwdata[0];
                REG_EQUAL_TOLERANCE: tolerance_reg  <= pwdata;
                default:             order_mode_reg <= order_mode_reg;
            endcase
        end
    end

    // List memory.
    entry_t           list_mem [LIST_DEPTH];
    entry_t           rd_data_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= list_mem[rd_addr];
    end

    // Control state.
    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] count_reg, count_next;
    key_t             last_key_reg, last_key_next;
    logic             ins_reg, ins_next;
    logic             out_valid_reg, out_valid_next;
    entry_t           cand_reg;
    key_t             out_key_reg;
    logic             out_kvalid_reg;
    logic             out_ins_reg;
    logic             load_out;
    logic             accept;
    logic [IDX_W-1:0] top_idx;
    logic             at_end;
    cmp_t             cmp;
    entry_t           in_entry;

    assign accept       = pair_in.valid && pair_in.ready;
    assign pair_in.ready = (state_reg == ST_IDLE);
    assign in_entry     = '{key: pair_in.pair_key, first_id: pair_in.first_id,
                            second_id: pair_in.second_id};

    tkpil_slot_cmp u_cmp (
        .cand       (cand_reg),
        .held       (rd_data_reg),
        .order_mode (order_mode_reg),
        .tolerance  (tolerance_reg),
        .result     (cmp)
    );

    always_comb
    begin
        // Destination of the first move: the first free entry, or the last entry if full.
        top_idx = (count_reg == FULL_CNT) ? LAST_IDX : count_reg[IDX_W-1:0];
        at_end  = (CNT_W'(idx_reg) == count_reg);

        state_next = state_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        ins_next   = ins_reg;
        rd_addr    = idx_reg + 1'b1;
        wr_en      = 1'b0;
        wr_addr    = idx_reg + 1'b1;
        wr_data    = rd_data_reg;
        load_out   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pair_in.valid)
                begin
                    rd_addr    = '0;
                    idx_next   = '0;
                    ins_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!at_end && cmp.duplicate)
                begin
                    state_next = ST_RESULT;
                end
                else if (at_end || cmp.beaten)
                begin
                    pos_next = idx_reg;
                    if (top_idx > idx_reg)
                    begin
                        rd_addr    = top_idx - 1'b1;
                        idx_next   = top_idx - 1'b1;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_WRITE;
                    end
                end
                else if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SHIFT:
            begin
                // Move the entry read last cycle one place down while reading the next one.
                wr_en = 1'b1;
                if (idx_reg == pos_reg)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    rd_addr  = idx_reg - 1'b1;
                    idx_next = idx_reg - 1'b1;
                end
            end
            ST_WRITE:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = cand_reg;
                count_next = (count_reg == FULL_CNT) ? count_reg : count_reg + 1'b1;
                ins_next   = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        last_key_next = (wr_en && (wr_addr == LAST_IDX)) ? wr_data.key : last_key_reg;
        out_valid_next = load_out ? 1'b1 : (res_out.ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            ins_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            last_key_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            ins_reg       <= ins_next;
            out_valid_reg <= out_valid_next;
            last_key_reg  <= last_key_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cand_reg <= in_entry;
        end
        if (load_out)
        begin
            out_ins_reg    <= ins_reg;
            out_kvalid_reg <= (count_reg == FULL_CNT);
            if (count_reg == FULL_CNT)
            begin
                out_key_reg <= last_key_reg;
            end
            else
            begin
                out_key_reg <= (order_mode_reg == ORDER_FURTHEST) ? WORST_FURTHEST
                                                                  : WORST_CLOSEST;
            end
        end
    end

    assign res_out.valid        = out_valid_reg;
    assign res_out.kth_key      = out_key_reg;
    assign res_out.kth_valid    = out_kvalid_reg;
    assign res_out.was_inserted = out_ins_reg;

    // Checks on the sequencing of the list update.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count exceeds list depth");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_SCAN))
        else $error("accepted request did not start a scan");

    a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> ((idx_reg >= pos_reg) && (idx_reg < top_idx)))
        else $error("shift source outside the moved range");

    a_write_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> ((count_reg != '0) && ins_reg))
        else $error("insertion left the list empty");

endmodule

// File: dv/tb_top.sv
// Testbench of the top-K pair insertion list: random and directed pairs checked against a list model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tkpil_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int PHASE_ITEMS  = 315;
    localparam int STALL_CYCLES = 400;

    typedef struct packed {
        key_t key;
        id_t  first_id;
        id_t  second_id;
    } pair_req_t;

    typedef struct packed {
        key_t kth_key;
        logic kth_valid;
        logic was_inserted;
    } kth_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    tkpil_in_if  pair_in ();
    tkpil_out_if res_out ();

    top_k_pair_insertion_list #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pair_in (pair_in),
        .res_out (res_out)
    );

    // Copy of the list and the registers as the block should hold them.
    key_t held_key    [LIST_DEPTH];
    id_t  held_first  [LIST_DEPTH];
    id_t  held_second [LIST_DEPTH];
    logic held_live   [LIST_DEPTH];
    logic order_mode_m;
    key_t tolerance_m;

    pair_req_t   pending_q [$];
    kth_result_t kth_expect_q [$];

    int pushed_total;
    int accepted_total;
    int fail_count;
    int cycle_count;
    int src_idle_pct;
    int snk_idle_pct;
    logic stall_armed;
    logic stall_done;
    int stall_left;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic kth_result_t rank_pair(key_t key, id_t a, id_t b);
        int pos;
        logic dup;
        logic stop;
        key_t diff;
        kth_result_t r;
        pos = LIST_DEPTH;
        dup = 1'b0;
        stop = 1'b0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (!stop)
            begin
                diff = (key > held_key[i]) ? key - held_key[i] : held_key[i] - key;
                if (!held_live[i])
                begin
                    pos = i;
                    stop = 1'b1;
                end
                else if (diff < tolerance_m)
                begin
                    // A near-equal key with a different pair does not stop the scan.
                    if ((a == held_first[i] && b == held_second[i]) ||
                        (a == held_second[i] && b == held_first[i]))
                    begin
                        dup = 1'b1;
                        stop = 1'b1;
                    end
                end
                else if ((order_mode_m == ORDER_FURTHEST) ? (key > held_key[i])
                                                          : (key < held_key[i]))
                begin
                    pos = i;
                    stop = 1'b1;
                end
            end
        end
        r.was_inserted = !dup && pos < LIST_DEPTH;
        if (r.was_inserted)
        begin
            for (int i = LIST_DEPTH - 1; i > pos; i--)
            begin
                held_key[i]    = held_key[i-1];
                held_first[i]  = held_first[i-1];
                held_second[i] = held_second[i-1];
                held_live[i]   = held_live[i-1];
            end
            held_key[pos]    = key;
            held_first[pos]  = a;
            held_second[pos] = b;
            held_live[pos]   = 1'b1;
        end
        r.kth_valid = held_live[LIST_DEPTH-1];
        if (r.kth_valid)
            r.kth_key = held_key[LIST_DEPTH-1];
        else
            r.kth_key = (order_mode_m == ORDER_FURTHEST) ? WORST_FURTHEST : WORST_CLOSEST;
        return r;
    endfunction

    // Most candidates land near keys already listed, so inserts, ties and repeats stay common.
    function automatic pair_req_t make_pair();
        int fill;
        int pick;
        int j;
        pair_req_t p;
        fill = 0;
        for (int i = 0; i < LIST_DEPTH; i++)
            if (held_live[i])
                fill++;
        pick = $urandom_range(99);
        if (fill == 0 || pick < 12)
        begin
            p.key = $urandom;
            p.first_id = id_t'($urandom);
            p.second_id = id_t'($urandom);
        end
        else
        begin
            j = $urandom_range(fill - 1);
            if (pick < 40)
            begin
                p.key = held_key[j] + key_t'($urandom_range(4)) - key_t'(2);
                if ($urandom_range(1))
                begin
                    p.first_id = held_first[j];
                    p.second_id = held_second[j];
                end
                else
                begin
                    p.first_id = held_second[j];
                    p.second_id = held_first[j];
                end
            end
            else
            begin
                p.key = held_key[j] + key_t'($urandom_range(32)) - key_t'(16);
                p.first_id = id_t'($urandom_range(15));
                p.second_id = id_t'($urandom_range(15));
            end
        end
        return p;
    endfunction

    task automatic push_pair(key_t key, id_t a, id_t b);
        pair_req_t p;
        p.key = key;
        p.first_id = a;
        p.second_id = b;
        pending_q.push_back(p);
        pushed_total++;
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_ORDER_MODE)
            order_mode_m = value[0];
        else
            tolerance_m = value;
    endtask

    task automatic wait_idle();
        while (accepted_total != pushed_total || kth_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(logic mode, key_t tol);
        write_reg(REG_ORDER_MODE, {31'd0, mode});
        write_reg(REG_EQUAL_TOLERANCE, tol);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            while (pending_q.size() >= 4)
                @(posedge clk);
            pending_q.push_back(make_pair());
            pushed_total++;
        end
        wait_idle();
    endtask

    // Sender: the next request is offered only once the current one is taken.
    always @(posedge clk)
    begin
        pair_req_t nxt;
        if (rst_n && (!pair_in.valid || pair_in.ready))
        begin
            if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                nxt = pending_q.pop_front();
                pair_in.valid     <= 1'b1;
                pair_in.pair_key  <= nxt.key;
                pair_in.first_id  <= nxt.first_id;
                pair_in.second_id <= nxt.second_id;
            end
            else
                pair_in.valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pair_in.valid && pair_in.ready)
        begin
            kth_expect_q.push_back(rank_pair(pair_in.pair_key, pair_in.first_id,
                                             pair_in.second_id));
            accepted_total++;
        end
    end

    // Receiver, with one long hold-off so that the list backs up into the input.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_out.ready <= 1'b0;
        else if (stall_armed && !stall_done)
        begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES;
            res_out.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            res_out.ready <= 1'b0;
        end
        else
            res_out.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        kth_result_t want;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            if (kth_expect_q.size() == 0)
            begin
                $error("result with no request waiting: kth_key %h", res_out.kth_key);
                fail_count++;
            end
            else
            begin
                want = kth_expect_q.pop_front();
                if (res_out.kth_key !== want.kth_key)
                begin
                    $error("kth_key expected %h got %h", want.kth_key, res_out.kth_key);
                    fail_count++;
                end
                if (res_out.kth_valid !== want.kth_valid)
                begin
                    $error("kth_valid expected %b got %b", want.kth_valid, res_out.kth_valid);
                    fail_count++;
                end
                if (res_out.was_inserted !== want.was_inserted)
                begin
                    $error("was_inserted expected %b got %b",
                           want.was_inserted, res_out.was_inserted);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_in.valid = 1'b0;
        pair_in.pair_key = '0;
        pair_in.first_id = '0;
        pair_in.second_id = '0;
        res_out.ready = 1'b0;
        pushed_total = 0;
        accepted_total = 0;
        fail_count = 0;
        cycle_count = 0;
        stall_armed = 1'b0;
        stall_done = 1'b0;
        stall_left = 0;
        src_idle_pct = 31;
        snk_idle_pct = 58;
        order_mode_m = ORDER_CLOSEST;
        tolerance_m = TOLERANCE_RESET;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            held_key[i] = '0;
            held_first[i] = '0;
            held_second[i] = '0;
            held_live[i] = 1'b0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part under reset settings: repeats in both id orders, equal keys with
        // other ids, the extremes, a full list with drop-outs and a candidate beating nothing.
        push_pair(32'h0001_0000, 31'd1, 31'd2);
        push_pair(32'h0001_0000, 31'd2, 31'd1);
        push_pair(32'h0001_0000, 31'd1, 31'd3);
        push_pair(32'h0000_0000, 31'd0, 31'd0);
        push_pair(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_pair(32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        push_pair(32'hFFFF_FFFE, 31'h5555_5555, 31'h2AAA_AAAA);
        for (int i = 1; i <= 13; i++)
            push_pair(key_t'(i * 256), id_t'(i), id_t'(i + 100));
        push_pair(32'hFFFF_FFFF, 31'd5, 31'd6);
        push_pair(32'h0000_0000, 31'd0, 31'd0);
        push_pair(32'h0000_0000, 31'd9, 31'd9);
        wait_idle();

        run_phase(ORDER_CLOSEST, 32'd8);
        run_phase(ORDER_FURTHEST, 32'd0);
        src_idle_pct = 58;
        snk_idle_pct = 31;
        run_phase(ORDER_FURTHEST, 32'hFFFF_FFFF);
        run_phase(ORDER_CLOSEST, 32'd0);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        stall_armed = 1'b1;
        run_phase(ORDER_FURTHEST, 32'd3);
        run_phase(ORDER_CLOSEST, TOLERANCE_RESET);

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
